[sv/obrs_pkg.sv]
`timescale 1ns / 1ps

package obrs_pkg;

   // Default sizes of the ring and the search command.
   localparam int DEPTH_DEF   = 64;
   localparam int CMD_MAX_DEF = 8;

   // Fixed field widths.
   localparam int KIND_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;
   localparam int FILL_W  = 7;
   localparam int CAP_W   = 7;
   localparam int LEN_W   = 4;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_LEN   = 2'd2;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIND  = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              ok;
      logic              found;
      logic              empty_res;
      logic              full_res;
      logic [FILL_W-1:0] fill;
      logic              last;
   } rsp_type;

endpackage

[sv/overwriting_byte_ring_with_search_top.sv]
`timescale 1ns / 1ps
//  Channel   Ports                          Direction  Moves
//  request   req_valid/req_ready/req_data   in         one item: kind, data, count
//  response  rsp_valid/rsp_ready/rsp_data   out        one result item per output
//  csr       csr_we/csr_index/csr_wdata     in         register write, no wait
//
//  Write, clear, unused kinds, an empty read and an empty peek give their result on acceptance;
//  a read waits for the RAM data. A peek issues and then emits each byte in turn, and a find
//  reads every stored byte first: each one passes through the single RAM read port.
//  The response register takes a new result in the cycle its old one leaves.
//  A stalled response holds the sequencer at its next result; nothing is dropped.
//  Reset is synchronous and empties the ring; the slot RAM is not cleared.

module overwriting_byte_ring_with_search_top
   import obrs_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEF,
   parameter int CMD_MAX = CMD_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int CIW = (CMD_MAX > 1) ? $clog2(CMD_MAX) : 1;

   typedef enum logic [4:0] {
      S_IDLE       = 5'b00001,
      S_READ       = 5'b00010,
      S_PEEK_ISSUE = 5'b00100,
      S_PEEK_DATA  = 5'b01000,
      S_FIND       = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic [AW-1:0]                rp_ff, rp_in;
   logic                         full_ff, full_in;
   logic [CW-1:0]                cap_ff, cap_in;
   logic [CMD_MAX-1:0][7:0]      cmd_ff, cmd_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [AW-1:0]                scan_ff, scan_in;
   logic [CW-1:0]                remain_ff, remain_in;
   logic [CW-1:0]                issued_ff, issued_in;
   logic [CW-1:0]                seen_ff, seen_in;
   logic                         hit_ff, hit_in;
   logic                         pend_ff, pend_in;
   logic [CMD_MAX-1:0][7:0]      win_ff, win_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   logic                         ram_we;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [7:0]                   ram_rdata;

   logic                         out_free;
   logic                         out_load;
   logic [7:0]                   out_byte_sel;
   logic                         out_ok;
   logic                         out_found;
   logic                         out_last;
   logic [CW-1:0]                fill_cur;
   logic [CW-1:0]                fill_next;
   logic [COUNT_W-1:0]           peek_n;
   logic [CMD_MAX-1:0][7:0]      win_shift;
   logic                         win_match;
   logic [COUNT_W-1:0]           cap_raw;
   logic [LEN_W-1:0]             len_raw;

   // Number of stored bytes for a given pointer state.
   function automatic logic [CW-1:0] fill_of(input logic [AW-1:0] wp,
                                              input logic [AW-1:0] rp,
                                              input logic          full,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] f;
      if (full) begin
         f = cap;
      end else if (wp >= rp) begin
         f = CW'(wp) - CW'(rp);
      end else begin
         f = cap + CW'(wp) - CW'(rp);
      end
      return f;
   endfunction

   // Advance a ring position, wrapping at the configured capacity.
   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                               input logic [CW-1:0] cap);
      logic [CW-1:0] p1;
      p1 = CW'(p) + CW'(1);
      return (p1 >= cap) ? '0 : p1[AW-1:0];
   endfunction

   obrs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (req_data.data),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign fill_cur = fill_of(wp_ff, rp_ff, full_ff, cap_ff);
   assign peek_n   = (req_data.count < COUNT_W'(fill_cur)) ? req_data.count
                                                          : COUNT_W'(fill_cur);
   assign cap_raw  = csr_wdata[COUNT_W-1:0];
   assign len_raw  = csr_wdata[LEN_W-1:0];

   // Search window: the newest byte enters at lane zero.
   always_comb begin
      logic [LEN_W-1:0] diff;
      diff      = '0;
      win_shift[0] = ram_rdata;
      for (int m = 1; m < CMD_MAX; m++) begin
         win_shift[m] = win_ff[m-1];
      end
      win_match = (8'(seen_ff) + 8'd1 >= 8'(len_ff));
      for (int m = 0; m < CMD_MAX; m++) begin
         if (LEN_W'(m) < len_ff) begin
            diff = len_ff - LEN_W'(m) - LEN_W'(1);
            if (win_shift[m] != cmd_ff[diff[CIW-1:0]]) begin
               win_match = 1'b0;
            end
         end
      end
   end

   // Sequencer, ring pointers and configuration registers.
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      full_in      = full_ff;
      cap_in       = cap_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      scan_in      = scan_ff;
      remain_in    = remain_ff;
      issued_in    = issued_ff;
      seen_in      = seen_ff;
      hit_in       = hit_ff;
      pend_in      = pend_ff;
      win_in       = win_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = rp_ff;
      out_load     = 1'b0;
      out_byte_sel = '0;
      out_ok       = 1'b0;
      out_found    = 1'b0;
      out_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req_data.kind)
                  KIND_WRITE: begin
                     ram_we = 1'b1;
                     wp_in  = next_pos(wp_ff, cap_ff);
                     if (full_ff) begin
                        rp_in = next_pos(rp_ff, cap_ff);
                     end
                     full_in  = (wp_in == rp_in);
                     out_load = 1'b1;
                  end
                  KIND_READ: begin
                     if (fill_cur == '0) begin
                        out_load = 1'b1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = rp_ff;
                        rp_in     = next_pos(rp_ff, cap_ff);
                        full_in   = 1'b0;
                        state_in  = S_READ;
                     end
                  end
                  KIND_CLEAR: begin
                     wp_in    = '0;
                     rp_in    = '0;
                     full_in  = 1'b0;
                     out_load = 1'b1;
                  end
                  KIND_PEEK: begin
                     if (peek_n == '0) begin
                        out_load = 1'b1;
                     end else begin
                        remain_in = CW'(peek_n);
                        scan_in   = rp_ff;
                        state_in  = S_PEEK_ISSUE;
                     end
                  end
                  KIND_FIND: begin
                     scan_in   = rp_ff;
                     issued_in = '0;
                     seen_in   = '0;
                     hit_in    = 1'b0;
                     pend_in   = 1'b0;
                     state_in  = S_FIND;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_byte_sel = ram_rdata;
               out_ok       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_PEEK_ISSUE: begin
            ram_re    = 1'b1;
            ram_raddr = scan_ff;
            scan_in   = next_pos(scan_ff, cap_ff);
            state_in  = S_PEEK_DATA;
         end
         S_PEEK_DATA: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_byte_sel = ram_rdata;
               out_ok       = 1'b1;
               out_last     = (remain_ff == CW'(1));
               remain_in    = remain_ff - CW'(1);
               state_in     = (remain_ff == CW'(1)) ? S_IDLE : S_PEEK_ISSUE;
            end
         end
         S_FIND: begin
            // Stream the stored bytes oldest first through the window.
            pend_in = 1'b0;
            if (issued_ff != fill_cur) begin
               ram_re    = 1'b1;
               ram_raddr = scan_ff;
               scan_in   = next_pos(scan_ff, cap_ff);
               issued_in = issued_ff + CW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               win_in  = win_shift;
               seen_in = seen_ff + CW'(1);
               if (win_match) begin
                  hit_in = 1'b1;
               end
            end else if (issued_ff == fill_cur && out_free) begin
               out_load  = 1'b1;
               out_found = hit_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes; a capacity write also empties the ring.
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY: begin
               if (cap_raw == '0) begin
                  cap_in = CW'(1);
               end else if (cap_raw > COUNT_W'(DEPTH)) begin
                  cap_in = CW'(DEPTH);
               end else begin
                  cap_in = cap_raw[CW-1:0];
               end
               wp_in   = '0;
               rp_in   = '0;
               full_in = 1'b0;
            end
            CSR_CMD_BYTES: begin
               cmd_in = csr_wdata[CMD_MAX*8-1:0];
            end
            CSR_CMD_LEN: begin
               if (len_raw == '0) begin
                  len_in = LEN_W'(1);
               end else if (len_raw > LEN_W'(CMD_MAX)) begin
                  len_in = LEN_W'(CMD_MAX);
               end else begin
                  len_in = len_raw;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result item: status is taken from the state after this item.
   assign fill_next = fill_of(wp_in, rp_in, full_in, cap_in);

   always_comb begin
      rsp_data_in           = rsp_data_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = out_byte_sel;
         rsp_data_in.ok        = out_ok;
         rsp_data_in.found     = out_found;
         rsp_data_in.empty_res = (fill_next == '0);
         rsp_data_in.full_res  = full_in;
         rsp_data_in.fill      = FILL_W'(fill_next);
         rsp_data_in.last      = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         full_ff      <= 1'b0;
         cap_ff       <= CW'(DEPTH);
         cmd_ff       <= '0;
         len_ff       <= LEN_W'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         full_ff      <= full_in;
         cap_ff       <= cap_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      remain_ff   <= remain_in;
      issued_ff   <= issued_in;
      seen_ff     <= seen_in;
      hit_ff      <= hit_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A full ring has its two pointers together.
   assert property (@(posedge clock) disable iff (reset) full_ff |-> (wp_ff == rp_ff))
      else $error("full flag set with pointers apart");

   // Both pointers stay inside the configured capacity.
   assert property (@(posedge clock) disable iff (reset)
                    (CW'(wp_ff) < cap_ff) && (CW'(rp_ff) < cap_ff))
      else $error("ring pointer beyond capacity");

   // A result that is not the last of its item only comes from a peek.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp_data_ff.last) |->
                    (state_ff == S_PEEK_ISSUE || state_ff == S_PEEK_DATA))
      else $error("non-final result outside a peek");

   // A hit needs at least as many stored bytes as the command holds.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_data_ff.found) |->
                    (8'(rsp_data_ff.fill) >= 8'(len_ff)))
      else $error("found reported on a ring shorter than the command");

endmodule

[sv/obrs_ram.sv]
`timescale 1ns / 1ps

module obrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
